// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/bdar_pkg.sv =====
`default_nettype none
package bdar_pkg;

   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 32;
   localparam int unsigned StampWidth    = 32;
   localparam int unsigned DebounceWidth = 8;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE_MS       = 2'd0,
      CSR_HOLD_BEFORE_MS    = 2'd1,
      CSR_REPEAT_INTERVAL   = 2'd2,
      CSR_REPEAT_ON         = 2'd3
   } csr_index_type;

   localparam logic [DebounceWidth-1:0] DebounceReset       = 8'd10;
   localparam logic [StampWidth-1:0]    HoldBeforeReset     = 32'd1000;
   localparam logic [StampWidth-1:0]    RepeatIntervalReset = 32'd333;

endpackage
`default_nettype wire

// ===== rtl/bdar_req_if.sv =====
`default_nettype none
interface bdar_req_if;
   logic        valid;
   logic        ready;
   logic        raw_level;
   logic [31:0] now_ms;

   modport source (output valid, output raw_level, output now_ms, input ready);
   modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface
`default_nettype wire

// ===== rtl/bdar_rsp_if.sv =====
`default_nettype none
interface bdar_rsp_if;
   logic valid;
   logic ready;
   logic level_stable;
   logic press_event;
   logic release_event;
   logic repeat_event;

   modport source (output valid, output level_stable, output press_event,
                   output release_event, output repeat_event, input ready);
   modport sink   (input valid, input level_stable, input press_event,
                   input release_event, input repeat_event, output ready);
endinterface
`default_nettype wire

// ===== rtl/button_debounce_autorepeat_unit.sv =====
// An accepted request transaction goes to the input register, then the
//   response register. Throughput: one transaction per cycle when the
//   response side is ready; the debounce and repeat timers are a handful
//   of 32-bit subtract/compare paths, evaluated combinationally.
// Reset (synchronous, active high) restores the default timing registers,
//   clears the debounce/repeat state and empties both pipeline registers.
`default_nettype none
`include "assert_macros.svh"
module button_debounce_autorepeat_unit
   import bdar_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   bdar_req_if.sink                      req_chan,
   bdar_rsp_if.source                    rsp_chan,
   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   // configuration
   logic [DebounceWidth-1:0] debounce_ms_ff;
   logic [StampWidth-1:0]    hold_ms_ff;
   logic [StampWidth-1:0]    interval_ms_ff;
   logic                     repeat_on_ff;

   // debounce state
   logic                  settled_ff, settled_in;
   logic                  prev_raw_ff, prev_raw_in;
   logic [StampWidth-1:0] change_stamp_ff, change_stamp_in;
   logic                  repeating_ff, repeating_in;
   logic [StampWidth-1:0] repeat_stamp_ff, repeat_stamp_in;

   // input stage
   logic                  in_valid_ff;
   logic                  in_raw_ff;
   logic [StampWidth-1:0] in_now_ff;

   // output stage
   logic out_valid_ff;
   logic out_level_ff, out_level_in;
   logic out_press_ff, out_press_in;
   logic out_release_ff, out_release_in;
   logic out_repeat_ff, out_repeat_in;

   logic advance;
   logic fire;
   logic [StampWidth-1:0] since_change;
   logic [StampWidth-1:0] since_repeat;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;

   assign since_change = in_now_ff - change_stamp_ff;
   assign since_repeat = in_now_ff - repeat_stamp_ff;

   always_comb begin
      settled_in      = settled_ff;
      prev_raw_in     = prev_raw_ff;
      change_stamp_in = change_stamp_ff;
      repeating_in    = repeating_ff;
      repeat_stamp_in = repeat_stamp_ff;
      out_press_in    = 1'b0;
      out_release_in  = 1'b0;
      out_repeat_in   = 1'b0;
      if (in_raw_ff != settled_ff) begin
         if (in_raw_ff == prev_raw_ff) begin
            if (since_change > {{(StampWidth-DebounceWidth){1'b0}}, debounce_ms_ff}) begin
               repeating_in   = 1'b0;
               settled_in     = in_raw_ff;
               out_press_in   = in_raw_ff;
               out_release_in = !in_raw_ff;
            end
         end else begin
            prev_raw_in     = in_raw_ff;
            change_stamp_in = in_now_ff;
         end
      end else if (repeat_on_ff && in_raw_ff) begin
         if (repeating_ff) begin
            if (since_repeat > interval_ms_ff) begin
               repeat_stamp_in = in_now_ff;
               out_repeat_in   = 1'b1;
            end
         end else if (since_change > hold_ms_ff) begin
            repeat_stamp_in = in_now_ff;
            out_repeat_in   = 1'b1;
            repeating_in    = 1'b1;
         end
      end
      out_level_in = settled_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DebounceReset;
         hold_ms_ff     <= HoldBeforeReset;
         interval_ms_ff <= RepeatIntervalReset;
         repeat_on_ff   <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE_MS:     debounce_ms_ff <= csr_wdata[DebounceWidth-1:0];
            CSR_HOLD_BEFORE_MS:  hold_ms_ff     <= csr_wdata[StampWidth-1:0];
            CSR_REPEAT_INTERVAL: interval_ms_ff <= csr_wdata[StampWidth-1:0];
            CSR_REPEAT_ON:       repeat_on_ff   <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settled_ff      <= 1'b0;
         prev_raw_ff     <= 1'b0;
         change_stamp_ff <= '0;
         repeating_ff    <= 1'b0;
         repeat_stamp_ff <= '0;
      end else if (fire) begin
         settled_ff      <= settled_in;
         prev_raw_ff     <= prev_raw_in;
         change_stamp_ff <= change_stamp_in;
         repeating_ff    <= repeating_in;
         repeat_stamp_ff <= repeat_stamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_raw_ff <= req_chan.raw_level;
         in_now_ff <= req_chan.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_level_ff   <= out_level_in;
         out_press_ff   <= out_press_in;
         out_release_ff <= out_release_in;
         out_repeat_ff  <= out_repeat_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.level_stable  = out_level_ff;
   assign rsp_chan.press_event   = out_press_ff;
   assign rsp_chan.release_event = out_release_ff;
   assign rsp_chan.repeat_event  = out_repeat_ff;

   `ASSERT_ALWAYS(a_one_event, clock, reset,
      !out_valid_ff || $countones({out_press_ff, out_release_ff, out_repeat_ff}) <= 1,
      "more than one event in a response transaction")
   `ASSERT_IMPLIES(a_press_level, clock, reset, out_valid_ff && out_press_ff,
      out_level_ff, "press event without pressed level")
   `ASSERT_IMPLIES(a_release_level, clock, reset, out_valid_ff && out_release_ff,
      !out_level_ff, "release event with pressed level")
   `ASSERT_IMPLIES(a_repeat_level, clock, reset, out_valid_ff && out_repeat_ff,
      out_level_ff && repeating_ff, "repeat event while released or not repeating")
   `ASSERT_NEXT(a_fire_loads, clock, reset, fire, out_valid_ff && settled_ff == out_level_ff,
      "processed transaction did not reach the response register")

endmodule
`default_nettype wire

// ===== tb/sv/button_debounce_autorepeat_unit_tb.sv =====
module button_debounce_autorepeat_unit_tb;
   import bdar_pkg::*;

   localparam int unsigned QuietLimit = 1000;
   localparam int unsigned DrainCycles = 4;

   typedef struct packed {
      logic level_stable;
      logic press_event;
      logic release_event;
      logic repeat_event;
   } outcome_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0] csr_wdata;

   bdar_req_if req_if();
   bdar_rsp_if rsp_if();

   button_debounce_autorepeat_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // predictor configuration
   logic [DebounceWidth-1:0] debounce_cfg = DebounceReset;
   logic [StampWidth-1:0] hold_cfg = HoldBeforeReset;
   logic [StampWidth-1:0] interval_cfg = RepeatIntervalReset;
   logic repeat_cfg = 1'b1;

   // predictor state
   logic settled = 1'b0;
   logic last_raw = 1'b0;
   logic [StampWidth-1:0] change_at = '0;
   logic repeating = 1'b0;
   logic [StampWidth-1:0] repeat_at = '0;

   outcome_type outcome_q[$];
   int unsigned fault_count = 0;
   int unsigned sample_count = 0;
   int unsigned quiet_cycles = 0;
   logic idle_on = 1'b1;
   logic [31:0] stamp_now = '0;

   function automatic outcome_type debounce_step(input logic raw, input logic [31:0] stamp);
      outcome_type ev;
      logic [31:0] elapsed;
      ev = '0;
      if (raw != settled) begin
         if (raw == last_raw) begin
            elapsed = stamp - change_at;
            if (elapsed > {24'd0, debounce_cfg}) begin
               repeating = 1'b0;
               settled = raw;
               if (raw) ev.press_event = 1'b1;
               else ev.release_event = 1'b1;
            end
         end else begin
            last_raw = raw;
            change_at = stamp;
         end
      end else if (repeat_cfg && raw) begin
         if (repeating) begin
            elapsed = stamp - repeat_at;
            if (elapsed > interval_cfg) begin
               repeat_at = stamp;
               ev.repeat_event = 1'b1;
            end
         end else begin
            elapsed = stamp - change_at;
            if (elapsed > hold_cfg) begin
               repeat_at = stamp;
               ev.repeat_event = 1'b1;
               repeating = 1'b1;
            end
         end
      end
      ev.level_stable = settled;
      return ev;
   endfunction

   task automatic report_fault(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      fault_count++;
   endtask

   task automatic check_field(input string name, input logic got, input logic want);
      if (got !== want)
         report_fault($sformatf("%s got %b expected %b", name, got, want));
   endtask

   task automatic send_sample(input logic raw, input logic [31:0] stamp);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid     <= 1'b1;
      req_if.raw_level <= raw;
      req_if.now_ms    <= stamp;
      do @(posedge clock); while (!req_if.ready);
      outcome_q.push_back(debounce_step(raw, stamp));
      sample_count++;
   endtask

   task automatic sample_after(input logic raw, input int unsigned step_max);
      stamp_now = stamp_now + $urandom_range(0, step_max);
      send_sample(raw, stamp_now);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_MS:     debounce_cfg = data[7:0];
         CSR_HOLD_BEFORE_MS:  hold_cfg = data;
         CSR_REPEAT_INTERVAL: interval_cfg = data;
         CSR_REPEAT_ON:       repeat_cfg = data[0];
         default: ;
      endcase
   endtask

   // bounce, hold, bounce, release
   task automatic press_cycle(input int unsigned step_max);
      int unsigned n;
      n = $urandom_range(0, 4);
      repeat (n) sample_after(1'($urandom_range(0, 1)), step_max);
      n = $urandom_range(2, 30);
      repeat (n) sample_after(1'b1, step_max);
      n = $urandom_range(0, 4);
      repeat (n) sample_after(1'($urandom_range(0, 1)), step_max);
      n = $urandom_range(2, 8);
      repeat (n) sample_after(1'b0, step_max);
   endtask

   task automatic test_default_timing();
      send_sample(1'b0, 32'd0);
      send_sample(1'b1, 32'd100);
      send_sample(1'b1, 32'd110);
      send_sample(1'b1, 32'd111);
      send_sample(1'b1, 32'd1100);
      send_sample(1'b1, 32'd1101);
      send_sample(1'b1, 32'd1434);
      send_sample(1'b1, 32'd1435);
      // bounce back to settled level keeps the earlier change time
      send_sample(1'b0, 32'd1500);
      send_sample(1'b1, 32'd1505);
      send_sample(1'b0, 32'd1511);
      // timestamp wrap
      send_sample(1'b1, 32'hFFFF_FFF8);
      send_sample(1'b1, 32'h0000_0003);
      // out-of-order timestamps
      send_sample(1'b0, 32'd2);
      send_sample(1'b0, 32'd1);
   endtask

   task automatic test_register_extremes();
      wait_idle();
      write_reg(CSR_DEBOUNCE_MS, 32'd0);
      write_reg(CSR_HOLD_BEFORE_MS, 32'd0);
      write_reg(CSR_REPEAT_INTERVAL, 32'd0);
      write_reg(CSR_REPEAT_ON, 32'd1);
      send_sample(1'b1, 32'd20);
      send_sample(1'b1, 32'd20);
      send_sample(1'b1, 32'd21);
      send_sample(1'b1, 32'd21);
      send_sample(1'b1, 32'd21);
      send_sample(1'b1, 32'd22);
      wait_idle();
      write_reg(CSR_DEBOUNCE_MS, 32'hFFFF_FFFF);
      write_reg(CSR_HOLD_BEFORE_MS, 32'hFFFF_FFFF);
      write_reg(CSR_REPEAT_INTERVAL, 32'hFFFF_FFFF);
      write_reg(CSR_REPEAT_ON, 32'hFFFF_FFFE);
      send_sample(1'b0, 32'd100);
      send_sample(1'b0, 32'd355);
      send_sample(1'b0, 32'd356);
      send_sample(1'b1, 32'd400);
      send_sample(1'b1, 32'd656);
      send_sample(1'b1, 32'hFFFF_FFFF);
      wait_idle();
      write_reg(CSR_REPEAT_ON, 32'hFFFF_FFFF);
      write_reg(CSR_HOLD_BEFORE_MS, 32'd5);
      send_sample(1'b1, 32'd700);
      send_sample(1'b1, 32'd699);
   endtask

   task automatic test_random_holds();
      int unsigned goal;
      int unsigned step_max;
      logic [31:0] junk;
      for (int phase = 0; phase < 10; phase++) begin
         wait_idle();
         idle_on = ($urandom_range(0, 3) != 0);
         junk = $urandom();
         write_reg(CSR_DEBOUNCE_MS, ($urandom_range(0, 7) == 0) ? junk :
                   ((junk & 32'hFFFF_FF00) | $urandom_range(0, 30)));
         write_reg(CSR_HOLD_BEFORE_MS, ($urandom_range(0, 9) == 0) ? $urandom() :
                   $urandom_range(0, 300));
         write_reg(CSR_REPEAT_INTERVAL, ($urandom_range(0, 9) == 0) ? $urandom() :
                   $urandom_range(0, 60));
         write_reg(CSR_REPEAT_ON, {junk[31:1], ($urandom_range(0, 3) != 0)});
         step_max = $urandom_range(1, 40);
         stamp_now = $urandom();
         goal = sample_count + 150;
         while (sample_count < goal) begin
            if ($urandom_range(0, 7) == 0) begin
               stamp_now = $urandom();
               send_sample(1'($urandom_range(0, 1)), stamp_now);
            end else begin
               press_cycle(step_max);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (outcome_q.size() == 0) begin
            report_fault("response transaction with no sample pending");
         end else begin
            want = outcome_q.pop_front();
            check_field("level_stable", rsp_if.level_stable, want.level_stable);
            check_field("press_event", rsp_if.press_event, want.press_event);
            check_field("release_event", rsp_if.release_event, want.release_event);
            check_field("repeat_event", rsp_if.repeat_event, want.repeat_event);
         end
      end
   end

   initial begin
      int unsigned stall;
      rsp_if.ready = 1'b0;
      forever begin
         stall = idle_on ? $urandom_range(0, 6) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("ERROR: no transaction for %0d cycles", QuietLimit);
            $display("button_debounce_autorepeat_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_DEBOUNCE_MS;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.raw_level = 1'b0;
      req_if.now_ms = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_default_timing();
      test_register_extremes();
      test_random_holds();
      wait_idle();
      if (fault_count == 0) begin
         $display("button_debounce_autorepeat_unit: match");
      end else begin
         $display("button_debounce_autorepeat_unit: mismatch");
      end
      $finish;
   end

endmodule
